// ----- rtl/tmg_pkg.sv -----
package tmg_pkg;

   localparam logic [1:0] OP_SCALE     = 2'd0;
   localparam logic [1:0] OP_TRANSLATE = 2'd1;
   localparam logic [1:0] OP_ROTATE    = 2'd2;
   localparam logic [1:0] OP_UNUSED    = 2'd3;

   localparam int FRAC_BITS    = 16;
   localparam int ATAN_ENTRIES = 30;

   // cordic constants: gain in signed q4.30, degrees to radians in unsigned q0.32
   localparam logic signed [33:0] CORDIC_GAIN_Q30 = 34'sd652032874;
   localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;

   // angle reduction: integer degrees biased positive, then mod 360 by reciprocal
   localparam logic [25:0] ANGLE_BIAS  = 26'd11796480;
   localparam logic [24:0] RECIP_360   = 25'd23860930;
   localparam int          RECIP_SHIFT = 33;
   localparam logic [25:0] DEG_360     = 26'd360;

   localparam logic signed [33:0] ATAN_Q30 [ATAN_ENTRIES] = '{
      34'sd843314857, 34'sd497837829, 34'sd263043837, 34'sd133525159, 34'sd67021687,
      34'sd33543516, 34'sd16775851, 34'sd8388437, 34'sd4194283, 34'sd2097149,
      34'sd1048576, 34'sd524288, 34'sd262144, 34'sd131072, 34'sd65536,
      34'sd32768, 34'sd16384, 34'sd8192, 34'sd4096, 34'sd2048,
      34'sd1024, 34'sd512, 34'sd256, 34'sd128, 34'sd64,
      34'sd32, 34'sd16, 34'sd8, 34'sd4, 34'sd2
   };

   typedef logic signed [31:0] fx_type;

   typedef struct packed {
      logic [1:0] op;
      fx_type     scale;
      fx_type     vx;
      fx_type     vy;
      fx_type     vz;
   } item_type;

   typedef logic [3:0][3:0][31:0] mat_type;

   function automatic fx_type sat64(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   // product rounded half up then saturated
   function automatic fx_type rnd_sat(input logic signed [63:0] p, input int fb);
      logic signed [63:0] t;
      t = p + (64'sd1 <<< (fb - 1));
      t = t >>> fb;
      return sat64(t);
   endfunction

   function automatic fx_type sat33(input logic signed [32:0] s);
      if (s[32] != s[31]) begin
         return s[32] ? 32'sh80000000 : 32'sh7fffffff;
      end
      return s[31:0];
   endfunction

   function automatic fx_type add_sat(input fx_type a, input fx_type b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      return sat33(s);
   endfunction

   function automatic fx_type sub_sat(input fx_type a, input fx_type b);
      logic signed [32:0] s;
      s = {a[31], a} - {b[31], b};
      return sat33(s);
   endfunction

endpackage

// ----- rtl/tmg_angle.sv -----
module tmg_angle (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  valid_i,
   input  tmg_pkg::fx_type       angle_i,
   input  tmg_pkg::item_type     item_i,
   output logic                  valid_o,
   output logic signed [33:0]    z_o,
   output logic                  negc_o,
   output logic                  negs_o,
   output tmg_pkg::item_type     item_o
);
   import tmg_pkg::*;

   localparam int DW = FRAC_BITS + 9;
   localparam int TW = FRAC_BITS + 7;
   localparam int PW = TW + 28;
   localparam logic [DW-1:0] Q90  = DW'(90) << FRAC_BITS;
   localparam logic [DW-1:0] Q180 = DW'(180) << FRAC_BITS;
   localparam logic [DW-1:0] Q270 = DW'(270) << FRAC_BITS;
   localparam logic [DW-1:0] Q360 = DW'(360) << FRAC_BITS;

   logic                 v1_ff, v2_ff, v3_ff, v4_ff;
   item_type             it1_ff, it2_ff, it3_ff, it4_ff;
   logic [25:0]          hu1_ff, hu2_ff;
   logic [FRAC_BITS-1:0] lo1_ff, lo2_ff;
   logic [16:0]          q2_ff;
   logic [50:0]          prod;
   logic [25:0]          rem;
   logic [DW-1:0]        d;
   logic [DW-1:0]        th_in;
   logic [TW-1:0]        th3_ff;
   logic                 nc_in, ns_in, nc3_ff, ns3_ff, nc4_ff, ns4_ff;
   logic [PW-1:0]        zp;
   logic signed [33:0]   z4_ff;

   assign prod = 51'(hu1_ff) * 51'(RECIP_360);

   always_comb begin
      rem = hu2_ff - 26'(q2_ff * 9'd360);
      if (rem >= DEG_360) begin
         rem = rem - DEG_360;
      end
      d = {rem[8:0], lo2_ff};
      nc_in = 1'b0;
      ns_in = 1'b0;
      priority if (d < Q90) begin
         th_in = d;
      end else if (d < Q180) begin
         th_in = Q180 - d;
         nc_in = 1'b1;
      end else if (d < Q270) begin
         th_in = d - Q180;
         nc_in = 1'b1;
         ns_in = 1'b1;
      end else begin
         th_in = Q360 - d;
         ns_in = 1'b1;
      end
      zp = PW'(th3_ff) * PW'(DEG2RAD_Q32) + (PW'(1) << (FRAC_BITS + 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= valid_i;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
      hu1_ff <= ANGLE_BIAS + 26'($signed(angle_i[31:FRAC_BITS]));
      lo1_ff <= angle_i[FRAC_BITS-1:0];
      it1_ff <= item_i;
      q2_ff  <= 17'(prod >> RECIP_SHIFT);
      hu2_ff <= hu1_ff;
      lo2_ff <= lo1_ff;
      it2_ff <= it1_ff;
      th3_ff <= th_in[TW-1:0];
      nc3_ff <= nc_in;
      ns3_ff <= ns_in;
      it3_ff <= it2_ff;
      z4_ff  <= 34'(zp >> (FRAC_BITS + 2));
      nc4_ff <= nc3_ff;
      ns4_ff <= ns3_ff;
      it4_ff <= it3_ff;
   end

   assign valid_o = v4_ff;
   assign z_o     = z4_ff;
   assign negc_o  = nc4_ff;
   assign negs_o  = ns4_ff;
   assign item_o  = it4_ff;

endmodule

// ----- rtl/tmg_cordic.sv -----
module tmg_cordic #(
   parameter int CORDIC_STEPS = 20
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_i,
   input  logic signed [33:0] z_i,
   input  logic               negc_i,
   input  logic               negs_i,
   input  tmg_pkg::item_type  item_i,
   output logic               valid_o,
   output tmg_pkg::fx_type    cos_o,
   output tmg_pkg::fx_type    sin_o,
   output tmg_pkg::item_type  item_o
);
   import tmg_pkg::*;

   localparam int NS = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   localparam logic signed [33:0] ONE = 34'sd1 <<< FRAC_BITS;
   localparam logic signed [33:0] RND = 34'sd1 <<< (29 - FRAC_BITS);

   logic signed [33:0] x_ff [NS];
   logic signed [33:0] y_ff [NS];
   logic signed [33:0] z_ff [NS];
   logic               v_ff [NS];
   logic               nc_ff [NS];
   logic               ns_ff [NS];
   item_type           it_ff [NS];

   for (genvar i = 0; i < NS; i++) begin : g_step
      logic signed [33:0] xi, yi, zi;
      logic               vi, nci, nsi;
      item_type           iti;
      if (i == 0) begin : g_first
         assign xi  = CORDIC_GAIN_Q30;
         assign yi  = '0;
         assign zi  = z_i;
         assign vi  = valid_i;
         assign nci = negc_i;
         assign nsi = negs_i;
         assign iti = item_i;
      end else begin : g_next
         assign xi  = x_ff[i-1];
         assign yi  = y_ff[i-1];
         assign zi  = z_ff[i-1];
         assign vi  = v_ff[i-1];
         assign nci = nc_ff[i-1];
         assign nsi = ns_ff[i-1];
         assign iti = it_ff[i-1];
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[i] <= 1'b0;
         end else begin
            v_ff[i] <= vi;
         end
         if (zi >= 0) begin
            x_ff[i] <= xi - (yi >>> i);
            y_ff[i] <= yi + (xi >>> i);
            z_ff[i] <= zi - ATAN_Q30[i];
         end else begin
            x_ff[i] <= xi + (yi >>> i);
            y_ff[i] <= yi - (xi >>> i);
            z_ff[i] <= zi + ATAN_Q30[i];
         end
         nc_ff[i] <= nci;
         ns_ff[i] <= nsi;
         it_ff[i] <= iti;
      end
   end

   logic signed [33:0] xr, yr;
   logic               vo_ff;
   fx_type             c_ff, s_ff;
   item_type           ito_ff;

   always_comb begin
      xr = (x_ff[NS-1] + RND) >>> (30 - FRAC_BITS);
      yr = (y_ff[NS-1] + RND) >>> (30 - FRAC_BITS);
      if (xr > ONE) begin
         xr = ONE;
      end else if (xr < -ONE) begin
         xr = -ONE;
      end
      if (yr > ONE) begin
         yr = ONE;
      end else if (yr < -ONE) begin
         yr = -ONE;
      end
      if (nc_ff[NS-1]) begin
         xr = -xr;
      end
      if (ns_ff[NS-1]) begin
         yr = -yr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= v_ff[NS-1];
      end
      c_ff   <= xr[31:0];
      s_ff   <= yr[31:0];
      ito_ff <= it_ff[NS-1];
   end

   assign valid_o = vo_ff;
   assign cos_o   = c_ff;
   assign sin_o   = s_ff;
   assign item_o  = ito_ff;

endmodule

// ----- rtl/tmg_rodrigues.sv -----
module tmg_rodrigues (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_i,
   input  tmg_pkg::fx_type   cos_i,
   input  tmg_pkg::fx_type   sin_i,
   input  tmg_pkg::item_type item_i,
   output logic              valid_o,
   output tmg_pkg::mat_type  mat_o
);
   import tmg_pkg::*;

   localparam fx_type ONE = 32'sd1 <<< FRAC_BITS;

   logic               v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   item_type           it1_ff, it2_ff, it3_ff, it4_ff;
   fx_type             c1_ff, c2_ff, c3_ff, c4_ff;
   fx_type             omc1_ff, omc2_ff;
   logic signed [63:0] pxx_ff, pxy_ff, pxz_ff, pyy_ff, pyz_ff, pzz_ff;
   logic signed [63:0] pxs_ff, pys_ff, pzs_ff;
   fx_type             axx_ff, axy_ff, axz_ff, ayy_ff, ayz_ff, azz_ff;
   fx_type             xs2_ff, ys2_ff, zs2_ff, xs3_ff, ys3_ff, zs3_ff, xs4_ff, ys4_ff, zs4_ff;
   logic signed [63:0] qxx_ff, qxy_ff, qxz_ff, qyy_ff, qyz_ff, qzz_ff;
   fx_type             bxx_ff, bxy_ff, bxz_ff, byy_ff, byz_ff, bzz_ff;
   mat_type            m_in, m_ff;

   always_comb begin
      m_in = '0;
      m_in[0][0] = ONE;
      m_in[1][1] = ONE;
      m_in[2][2] = ONE;
      m_in[3][3] = ONE;
      unique case (it4_ff.op)
         OP_SCALE: begin
            m_in[0][0] = it4_ff.scale;
            m_in[1][1] = it4_ff.scale;
            m_in[2][2] = it4_ff.scale;
         end
         OP_TRANSLATE: begin
            m_in[3][0] = it4_ff.vx;
            m_in[3][1] = it4_ff.vy;
            m_in[3][2] = it4_ff.vz;
         end
         OP_ROTATE: begin
            m_in[0][0] = add_sat(bxx_ff, c4_ff);
            m_in[1][0] = add_sat(bxy_ff, zs4_ff);
            m_in[2][0] = sub_sat(bxz_ff, ys4_ff);
            m_in[0][1] = sub_sat(bxy_ff, zs4_ff);
            m_in[1][1] = add_sat(byy_ff, c4_ff);
            m_in[2][1] = add_sat(byz_ff, xs4_ff);
            m_in[0][2] = add_sat(bxz_ff, ys4_ff);
            m_in[1][2] = sub_sat(byz_ff, xs4_ff);
            m_in[2][2] = add_sat(bzz_ff, c4_ff);
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else begin
         v1_ff <= valid_i;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
      // raw axis products
      pxx_ff  <= item_i.vx * item_i.vx;
      pxy_ff  <= item_i.vx * item_i.vy;
      pxz_ff  <= item_i.vx * item_i.vz;
      pyy_ff  <= item_i.vy * item_i.vy;
      pyz_ff  <= item_i.vy * item_i.vz;
      pzz_ff  <= item_i.vz * item_i.vz;
      pxs_ff  <= item_i.vx * sin_i;
      pys_ff  <= item_i.vy * sin_i;
      pzs_ff  <= item_i.vz * sin_i;
      omc1_ff <= sub_sat(ONE, cos_i);
      c1_ff   <= cos_i;
      it1_ff  <= item_i;
      // round and saturate
      axx_ff  <= rnd_sat(pxx_ff, FRAC_BITS);
      axy_ff  <= rnd_sat(pxy_ff, FRAC_BITS);
      axz_ff  <= rnd_sat(pxz_ff, FRAC_BITS);
      ayy_ff  <= rnd_sat(pyy_ff, FRAC_BITS);
      ayz_ff  <= rnd_sat(pyz_ff, FRAC_BITS);
      azz_ff  <= rnd_sat(pzz_ff, FRAC_BITS);
      xs2_ff  <= rnd_sat(pxs_ff, FRAC_BITS);
      ys2_ff  <= rnd_sat(pys_ff, FRAC_BITS);
      zs2_ff  <= rnd_sat(pzs_ff, FRAC_BITS);
      omc2_ff <= omc1_ff;
      c2_ff   <= c1_ff;
      it2_ff  <= it1_ff;
      // times one minus cosine
      qxx_ff  <= axx_ff * omc2_ff;
      qxy_ff  <= axy_ff * omc2_ff;
      qxz_ff  <= axz_ff * omc2_ff;
      qyy_ff  <= ayy_ff * omc2_ff;
      qyz_ff  <= ayz_ff * omc2_ff;
      qzz_ff  <= azz_ff * omc2_ff;
      xs3_ff  <= xs2_ff;
      ys3_ff  <= ys2_ff;
      zs3_ff  <= zs2_ff;
      c3_ff   <= c2_ff;
      it3_ff  <= it2_ff;
      bxx_ff  <= rnd_sat(qxx_ff, FRAC_BITS);
      bxy_ff  <= rnd_sat(qxy_ff, FRAC_BITS);
      bxz_ff  <= rnd_sat(qxz_ff, FRAC_BITS);
      byy_ff  <= rnd_sat(qyy_ff, FRAC_BITS);
      byz_ff  <= rnd_sat(qyz_ff, FRAC_BITS);
      bzz_ff  <= rnd_sat(qzz_ff, FRAC_BITS);
      xs4_ff  <= xs3_ff;
      ys4_ff  <= ys3_ff;
      zs4_ff  <= zs3_ff;
      c4_ff   <= c3_ff;
      it4_ff  <= it3_ff;
      m_ff    <= m_in;
   end

   assign valid_o = v5_ff;
   assign mat_o   = m_ff;

endmodule

// ----- rtl/transform_matrix_generator.sv -----
// transform matrix generator
// input: raise start with op, scale, angle_deg and vec_x/y/z on the
// req_ ports; the beat is taken on a rising edge where start is high and busy
// is low. busy stays high after each accepted beat until the hold counter has
// run down to zero, so items are spaced to match the four row beats each one
// yields on the single result channel.
// output: four row beats, row 0 first, on consecutive cycles, each marked by
// rsp_valid for one cycle; rsp_last_row is set on row 3. the receiver cannot
// hold results off, so there is no back pressure anywhere in the block.
// pipeline: the path runs through the angle reduction stages, one pipeline
// stage per cordic iteration and the product stages of the rotation matrix,
// ahead of the row serializer. all work is pipelined, so items overlap.
// reset: clears the valid bits and the busy counter; nothing is in flight
// afterwards and no beat is issued until a new item is accepted.
module transform_matrix_generator #(
   parameter int CORDIC_STEPS = 20
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_op,
   input  tmg_pkg::fx_type        req_scale,
   input  tmg_pkg::fx_type        req_angle_deg,
   input  tmg_pkg::fx_type        req_vec_x,
   input  tmg_pkg::fx_type        req_vec_y,
   input  tmg_pkg::fx_type        req_vec_z,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_row_index,
   output tmg_pkg::fx_type        rsp_elem0,
   output tmg_pkg::fx_type        rsp_elem1,
   output tmg_pkg::fx_type        rsp_elem2,
   output tmg_pkg::fx_type        rsp_elem3,
   output logic                   rsp_last_row
);
   import tmg_pkg::*;

   logic [1:0]         hold_ff, hold_in;
   logic               accept;
   item_type           item;
   logic               a_valid, a_negc, a_negs;
   logic signed [33:0] a_z;
   item_type           a_item, c_item;
   logic               c_valid;
   fx_type             c_cos, c_sin;
   logic               m_valid;
   mat_type            m_mat;
   mat_type            mat_ff;
   logic               send_ff;
   logic [1:0]         row_ff;

   assign accept = start & ~busy;
   assign busy   = (hold_ff != 2'd0);
   assign item   = '{op: req_op, scale: req_scale, vx: req_vec_x,
                     vy: req_vec_y, vz: req_vec_z};

   always_comb begin
      hold_in = hold_ff;
      if (accept) begin
         hold_in = 2'd3;
      end else if (hold_ff != 2'd0) begin
         hold_in = hold_ff - 2'd1;
      end
   end

   tmg_angle u_angle (
      .clock   (clock),
      .reset   (reset),
      .valid_i (accept),
      .angle_i (req_angle_deg),
      .item_i  (item),
      .valid_o (a_valid),
      .z_o     (a_z),
      .negc_o  (a_negc),
      .negs_o  (a_negs),
      .item_o  (a_item)
   );

   tmg_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .valid_i (a_valid),
      .z_i     (a_z),
      .negc_i  (a_negc),
      .negs_i  (a_negs),
      .item_i  (a_item),
      .valid_o (c_valid),
      .cos_o   (c_cos),
      .sin_o   (c_sin),
      .item_o  (c_item)
   );

   tmg_rodrigues u_rodrigues (
      .clock   (clock),
      .reset   (reset),
      .valid_i (c_valid),
      .cos_i   (c_cos),
      .sin_i   (c_sin),
      .item_i  (c_item),
      .valid_o (m_valid),
      .mat_o   (m_mat)
   );

   // row serializer
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff <= 2'd0;
         send_ff <= 1'b0;
         row_ff  <= 2'd0;
      end else begin
         hold_ff <= hold_in;
         if (m_valid) begin
            send_ff <= 1'b1;
            row_ff  <= 2'd0;
         end else if (send_ff) begin
            row_ff <= row_ff + 2'd1;
            if (row_ff == 2'd3) begin
               send_ff <= 1'b0;
            end
         end
      end
      if (m_valid) begin
         mat_ff <= m_mat;
      end
   end

   assign rsp_valid     = send_ff;
   assign rsp_row_index = row_ff;
   assign rsp_elem0     = mat_ff[row_ff][0];
   assign rsp_elem1     = mat_ff[row_ff][1];
   assign rsp_elem2     = mat_ff[row_ff][2];
   assign rsp_elem3     = mat_ff[row_ff][3];
   assign rsp_last_row  = send_ff & (row_ff == 2'd3);

   a_accept_holds: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy && hold_ff == 2'd3)
      else $error("busy not raised after accepted beat");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      m_valid |-> !send_ff || row_ff == 2'd3)
      else $error("new matrix arrived while rows still pending");

   a_rows_in_order: assert property (@(posedge clock) disable iff (reset)
      send_ff && row_ff != 2'd3 |=> send_ff && row_ff == $past(row_ff) + 2'd1)
      else $error("row beats not consecutive");

   a_row0_source: assert property (@(posedge clock) disable iff (reset)
      $rose(send_ff) |-> row_ff == 2'd0)
      else $error("matrix started on a row other than 0");

endmodule
